[src/ksb_pkg.sv]
// Shared types and codes for the k-stacks shared buffer unit.
package ksb_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Value store command for the current beat.
  typedef struct packed {
    logic wr;
    logic rd;
  } val_cmd_t;

endpackage

[src/ksb_stack_ctrl.sv]
// Stack heads, free list and slot link store with one-read lookahead caches.
module ksb_stack_ctrl #(
  parameter int NUM_STACKS = 4,
  parameter int SLOT_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic                          kind,
  input  logic [1:0]                    stack_id,
  output ksb_pkg::status_t              status_next,
  output logic                          full_next,
  output logic                          empty_next,
  output ksb_pkg::val_cmd_t             val_cmd,
  output logic [$clog2(SLOT_COUNT)-1:0] val_addr
);
  import ksb_pkg::*;

  localparam int PW = $clog2(SLOT_COUNT + 1);
  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [PW-1:0] NONE = PW'(SLOT_COUNT);

  typedef logic [PW-1:0] ptr_t;

  ptr_t link_mem [SLOT_COUNT];

  // free_link and head_link cache the link of the slot their head names.
  // A pending flag means the cache is still in flight in the read register.
  ptr_t free_head, free_head_next;
  ptr_t free_link, free_link_next;
  ptr_t wm, wm_next;                    // slots at or above wm never used
  ptr_t head [NUM_STACKS];
  ptr_t head_next [NUM_STACKS];
  ptr_t head_link [NUM_STACKS];
  ptr_t head_link_next [NUM_STACKS];
  logic pend_free, pend_free_next;
  logic [NUM_STACKS-1:0] pend_head, pend_head_next;

  ptr_t rd_link;
  ptr_t rd_inc;
  logic rd_mem;

  ptr_t rd_fix, free_link_eff, head_cur, hl_cur, head_sel_next;
  ptr_t hl_eff [NUM_STACKS];
  logic [NUM_STACKS-1:0] sel;
  logic sid_ok, free_ok, head_ok, is_push, push_ok, pop_ok;
  logic lw_en, rd_en, use_mem;
  ptr_t lw_addr, lw_data, rd_addr;

  always_comb begin
    rd_fix        = rd_mem ? rd_link : rd_inc;
    free_link_eff = pend_free ? rd_fix : free_link;
    head_cur      = NONE;
    hl_cur        = NONE;
    for (int k = 0; k < NUM_STACKS; k++) begin
      hl_eff[k] = pend_head[k] ? rd_fix : head_link[k];
      sel[k]    = (int'(stack_id) == k);
      if (sel[k]) begin
        head_cur = head[k];
        hl_cur   = hl_eff[k];
      end
    end
    sid_ok  = |sel;
    free_ok = free_head < NONE;
    head_ok = head_cur < NONE;
    is_push = (kind == KIND_PUSH);
    push_ok = go && is_push && sid_ok && free_ok;
    pop_ok  = go && !is_push && sid_ok && head_ok;

    status_next = ST_OK;
    if (is_push && !(sid_ok && free_ok)) status_next = ST_OVERFLOW;
    if (!is_push && !(sid_ok && head_ok)) status_next = ST_UNDERFLOW;

    // pending reads retire into the caches every cycle
    free_head_next = free_head;
    free_link_next = free_link_eff;
    wm_next        = wm;
    pend_free_next = 1'b0;
    pend_head_next = '0;
    for (int k = 0; k < NUM_STACKS; k++) begin
      head_next[k]      = head[k];
      head_link_next[k] = hl_eff[k];
    end
    head_sel_next = head_cur;
    lw_en   = 1'b0;
    lw_addr = free_head;
    lw_data = head_cur;
    rd_en   = 1'b0;
    rd_addr = free_link_eff;

    if (push_ok) begin
      // first free slot becomes the new top; fetch the link after it
      for (int k = 0; k < NUM_STACKS; k++) begin
        if (sel[k]) begin
          head_next[k]      = free_head;
          head_link_next[k] = head_cur;
        end
      end
      head_sel_next  = free_head;
      free_head_next = free_link_eff;
      pend_free_next = 1'b1;
      if (free_head == wm) wm_next = wm + PW'(1);
      lw_en   = 1'b1;
      lw_addr = free_head;
      lw_data = head_cur;
      rd_en   = 1'b1;
      rd_addr = free_link_eff;
    end

    if (pop_ok) begin
      // top slot goes to the front of the free list
      for (int k = 0; k < NUM_STACKS; k++) begin
        if (sel[k]) begin
          head_next[k] = hl_cur;
        end
      end
      pend_head_next = sel;
      head_sel_next  = hl_cur;
      free_head_next = head_cur;
      free_link_next = free_head;
      lw_en   = 1'b1;
      lw_addr = head_cur;
      lw_data = free_head;
      rd_en   = 1'b1;
      rd_addr = hl_cur;
    end

    // untouched slots still hold their reset link, i+1
    use_mem    = rd_addr < wm_next;
    full_next  = !(free_head_next < NONE);
    empty_next = !(head_sel_next < NONE);

    val_cmd.wr = push_ok;
    val_cmd.rd = pop_ok;
    val_addr   = is_push ? free_head[IW-1:0] : head_cur[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      free_link <= PW'(1);
      wm        <= '0;
      pend_free <= 1'b0;
      pend_head <= '0;
      rd_mem    <= 1'b0;
      for (int k = 0; k < NUM_STACKS; k++) begin
        head[k]      <= NONE;
        head_link[k] <= NONE;
      end
    end else begin
      free_head <= free_head_next;
      free_link <= free_link_next;
      wm        <= wm_next;
      pend_free <= pend_free_next;
      pend_head <= pend_head_next;
      if (rd_en) rd_mem <= use_mem;
      for (int k = 0; k < NUM_STACKS; k++) begin
        head[k]      <= head_next[k];
        head_link[k] <= head_link_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) link_mem[lw_addr[IW-1:0]] <= lw_data;
    if (rd_en) rd_inc <= rd_addr + PW'(1);
    if (rd_en && use_mem) rd_link <= link_mem[rd_addr[IW-1:0]];
  end

endmodule

[src/ksb_value_store.sv]
// Slot value memory with registered read port.
module ksb_value_store #(
  parameter int SLOT_COUNT  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  ksb_pkg::val_cmd_t             cmd,
  input  logic [$clog2(SLOT_COUNT)-1:0] addr,
  input  logic [VALUE_WIDTH-1:0]        wdata,
  output logic [VALUE_WIDTH-1:0]        rdata
);
  import ksb_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];

  // read data only moves on a pop, so it holds while the result stalls
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[addr] <= wdata;
    if (cmd.rd) rdata <= mem[addr];
  end

endmodule

[src/k_stacks_shared_buffer_unit.sv]
// Top level: NUM_STACKS stacks sharing one slot store through a linked free list.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+--------------------------------------------
//   input   | in_valid  | in_stall  | kind, stack_id, push_value
//   output  | out_valid | out_stall | pop_value, status, store_full, stack_empty
//
// One beat per cycle sustained while out_stall is low; an accepted input beat is held in the
// input register and loads the result register when it executes.
// For the pointer update of each beat, the link after each head is kept in a cache
// register, refilled by one link store read per beat.
// Reset is synchronous; no clearing pass: slots at or above a high-water mark read
// their reset link. The value store is not cleared.
// out_stall holds the result register and, when it is full, the input register.
module k_stacks_shared_buffer_unit #(
  parameter int NUM_STACKS  = 4,
  parameter int SLOT_COUNT  = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    kind,
  input  logic [1:0]              stack_id,
  input  logic signed [31:0]      push_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      pop_value,
  output ksb_pkg::status_t        status,
  output logic                    store_full,
  output logic                    stack_empty
);
  import ksb_pkg::*;

  // input register
  logic        s1_valid;
  logic        s1_kind;
  logic [1:0]  s1_stack_id;
  logic [31:0] s1_value;

  // result register (pop data sits in the value store read register)
  logic        pop_ok;

  logic go;
  status_t status_next;
  logic full_next, empty_next;
  val_cmd_t val_cmd;
  logic [$clog2(SLOT_COUNT)-1:0] val_addr;
  logic [VALUE_WIDTH-1:0] rdata;

  // the held beat executes when the result register can take its answer
  assign go       = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !go;

  ksb_stack_ctrl #(
    .NUM_STACKS (NUM_STACKS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .kind        (s1_kind),
    .stack_id    (s1_stack_id),
    .status_next (status_next),
    .full_next   (full_next),
    .empty_next  (empty_next),
    .val_cmd     (val_cmd),
    .val_addr    (val_addr)
  );

  ksb_value_store #(
    .SLOT_COUNT  (SLOT_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_values (
    .clk   (clk),
    .cmd   (val_cmd),
    .addr  (val_addr),
    .wdata (VALUE_WIDTH'(s1_value)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (!out_valid || !out_stall) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind     <= kind;
      s1_stack_id <= stack_id;
      s1_value    <= push_value;
    end
    if (go) begin
      status      <= status_next;
      store_full  <= full_next;
      stack_empty <= empty_next;
      pop_ok      <= val_cmd.rd;
    end
  end

  // popped value is zero unless the pop succeeded
  assign pop_value = pop_ok ? 32'(rdata) : '0;

endmodule

[src/ksb_checker.sv]
// Port-level checks for the k-stacks shared buffer unit, bound to the top level.
module ksb_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pop_value,
  input ksb_pkg::status_t   status,
  input logic               store_full,
  input logic               stack_empty
);
  import ksb_pkg::*;

  // a failed operation never carries data
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pop_value == 32'sd0)
    else $error("nonzero pop_value on failed beat");

  // underflow means the addressed stack is empty
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> stack_empty)
    else $error("underflow on non-empty stack");

  // an ok beat that leaves the stack empty was a pop, which frees a slot
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && stack_empty |-> !store_full)
    else $error("store full after emptying pop");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pop_value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind k_stacks_shared_buffer_unit ksb_checker u_ksb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pop_value   (pop_value),
  .status      (status),
  .store_full  (store_full),
  .stack_empty (stack_empty)
);
